/* src/cqe_pkg.sv */
package cqe_pkg;

  // Command codes carried by an input beat.
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_SHOW = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Work kinds handed from the front end to the back end.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_WALK   = 2'd3;

  localparam int DATA_W = 32;
  // Wide enough for the largest supported capacity of 64 entries.
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         addr;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic                     is_empty;
    logic                     is_full;
  } op_t;

endpackage

/* src/cqe_ram.sv */
module cqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/cqe_front.sv */
module cqe_front #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [1:0]                        cmd,
  input  logic signed [cqe_pkg::DATA_W-1:0] value,
  input  logic                              op_full,
  output logic                              op_push,
  output cqe_pkg::op_t                      op
);

  localparam int AW = $clog2(CAPACITY);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic          occupied;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic          occupied_next;

  logic [AW-1:0] tail_inc;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc2;
  logic          full;
  logic [AW:0]   span;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    wrap_inc = (i == AW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  assign tail_inc  = wrap_inc(tail);
  assign head_inc  = wrap_inc(head);
  assign tail_inc2 = wrap_inc(tail_inc);
  assign full      = occupied && (tail_inc == head);

  // Number of stored entries, 1 to CAPACITY when occupied.
  always_comb begin
    span = {1'b0, tail} - {1'b0, head} + (AW+1)'(1);
    if (tail < head) begin
      span = span + (AW+1)'(CAPACITY);
    end
  end

  assign item_ready = !op_full;
  assign op_push    = item_valid && item_ready;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    occupied_next = occupied;
    op.kind       = cqe_pkg::KIND_STATUS;
    op.addr       = cqe_pkg::IDX_W'(head);
    op.count      = cqe_pkg::CNT_W'(span);
    op.value      = value;
    op.status     = cqe_pkg::ST_EMPTY;
    op.is_empty   = !occupied;
    op.is_full    = full;
    unique case (cmd)
      cqe_pkg::CMD_ENQ: begin
        if (full) begin
          op.status = cqe_pkg::ST_OVF;
        end else if (!occupied) begin
          head_next     = '0;
          tail_next     = '0;
          occupied_next = 1'b1;
          op.kind       = cqe_pkg::KIND_WRITE;
          op.addr       = '0;
          op.status     = cqe_pkg::ST_OK;
          op.is_empty   = 1'b0;
          op.is_full    = 1'b0;
        end else begin
          tail_next   = tail_inc;
          op.kind     = cqe_pkg::KIND_WRITE;
          op.addr     = cqe_pkg::IDX_W'(tail_inc);
          op.status   = cqe_pkg::ST_OK;
          op.is_empty = 1'b0;
          op.is_full  = (tail_inc2 == head);
        end
      end
      cqe_pkg::CMD_DEQ: begin
        if (occupied) begin
          op.kind    = cqe_pkg::KIND_READ;
          op.status  = cqe_pkg::ST_OK;
          op.is_full = 1'b0;
          if (head == tail) begin
            occupied_next = 1'b0;
            head_next     = '0;
            tail_next     = '0;
            op.is_empty   = 1'b1;
          end else begin
            head_next = head_inc;
          end
        end
      end
      cqe_pkg::CMD_PEEK: begin
        if (occupied) begin
          op.kind   = cqe_pkg::KIND_READ;
          op.status = cqe_pkg::ST_OK;
        end
      end
      cqe_pkg::CMD_SHOW: begin
        if (occupied) begin
          op.kind   = cqe_pkg::KIND_WALK;
          op.status = cqe_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      occupied <= 1'b0;
    end else if (op_push) begin
      head     <= head_next;
      tail     <= tail_next;
      occupied <= occupied_next;
    end
  end

endmodule

/* src/cqe_opq.sv */
module cqe_opq (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cqe_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output cqe_pkg::op_t head_op
);

  cqe_pkg::op_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign head_op  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* src/cqe_back.sv */
module cqe_back #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  input  cqe_pkg::op_t                      op,
  output logic                              op_pop,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [cqe_pkg::DATA_W-1:0] data,
  output logic [1:0]                        status,
  output logic                              last,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_WALK = 1'b1;

  logic          state;
  logic          state_next;
  logic [AW-1:0] walk_addr;
  logic [AW-1:0] walk_addr_next;
  logic [AW:0]   remain;
  logic [AW:0]   remain_next;
  logic          walk_empty;
  logic          walk_full;
  logic          use_ram;

  logic                      can_issue;
  logic                      load;
  logic                      n_use_ram;
  logic [1:0]                n_status;
  logic                      n_last;
  logic                      n_empty;
  logic                      n_full;
  logic                      ram_we;
  logic                      ram_re;
  logic [AW-1:0]             ram_addr;
  logic [cqe_pkg::DATA_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    wrap_inc = (i == AW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  cqe_ram #(
    .WIDTH (cqe_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (op.value),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign can_issue = !result_valid || result_ready;
  assign data      = use_ram ? ram_rdata : '0;

  always_comb begin
    state_next     = state;
    walk_addr_next = walk_addr;
    remain_next    = remain;
    op_pop         = 1'b0;
    load           = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = op.addr[AW-1:0];
    n_use_ram      = 1'b0;
    n_status       = op.status;
    n_last         = 1'b1;
    n_empty        = op.is_empty;
    n_full         = op.is_full;
    if (state == BK_WALK) begin
      if (can_issue) begin
        load           = 1'b1;
        ram_re         = 1'b1;
        ram_addr       = walk_addr;
        n_use_ram      = 1'b1;
        n_status       = cqe_pkg::ST_OK;
        n_last         = (remain == (AW+1)'(1));
        n_empty        = walk_empty;
        n_full         = walk_full;
        walk_addr_next = wrap_inc(walk_addr);
        remain_next    = remain - (AW+1)'(1);
        if (remain == (AW+1)'(1)) begin
          state_next = BK_IDLE;
        end
      end
    end else if (op_valid && can_issue) begin
      op_pop = 1'b1;
      load   = 1'b1;
      unique case (op.kind)
        cqe_pkg::KIND_WRITE: begin
          ram_we = 1'b1;
        end
        cqe_pkg::KIND_READ: begin
          ram_re    = 1'b1;
          n_use_ram = 1'b1;
        end
        cqe_pkg::KIND_STATUS: begin
        end
        cqe_pkg::KIND_WALK: begin
          ram_re         = 1'b1;
          n_use_ram      = 1'b1;
          n_last         = (op.count[AW:0] == (AW+1)'(1));
          walk_addr_next = wrap_inc(op.addr[AW-1:0]);
          remain_next    = op.count[AW:0] - (AW+1)'(1);
          if (op.count[AW:0] != (AW+1)'(1)) begin
            state_next = BK_WALK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_addr <= walk_addr_next;
    remain    <= remain_next;
    if (op_pop && (op.kind == cqe_pkg::KIND_WALK)) begin
      walk_empty <= op.is_empty;
      walk_full  <= op.is_full;
    end
    if (load) begin
      use_ram  <= n_use_ram;
      status   <= n_status;
      last     <= n_last;
      is_empty <= n_empty;
      is_full  <= n_full;
    end
  end

endmodule

/* src/circular_queue_engine_core.sv */
// A result beat passes through an operation queue entry and the back end's output register;
// consumer stalls and earlier display beats delay it. Enqueue, dequeue and peek sustain one
// beat per cycle while the consumer is ready and no display is walking; display emits one
// result per stored entry, one per cycle, bounded by the single read port of the slot RAM.
// Reset (synchronous, active high) empties the queue and both internal pipelines;
// the slot RAM contents are not cleared and are only ever read after being written.
module circular_queue_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [1:0]                        cmd,
  input  logic signed [cqe_pkg::DATA_W-1:0] value,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [cqe_pkg::DATA_W-1:0] data,
  output logic [1:0]                        status,
  output logic                              last,
  output logic                              is_empty,
  output logic                              is_full
);

  // The front end owns the head and tail pointers and the occupied flag. It
  // decides every command in the cycle its beat is accepted, so the queue
  // state it keeps always reflects all accepted beats. Each decision is
  // packed into an operation that says what the back end must do with the
  // slot RAM: write a word, read one word, walk a range, or just report.
  cqe_pkg::op_t push_op;
  cqe_pkg::op_t head_op;
  logic         op_push;
  logic         op_pop;
  logic         op_full;
  logic         op_nonempty;

  cqe_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .value      (value),
    .op_full    (op_full),
    .op_push    (op_push),
    .op         (push_op)
  );

  // A two-entry operation queue lets the front keep accepting beats while
  // the back end is stalled by the consumer or busy walking for a display.
  cqe_opq u_opq (
    .clk      (clk),
    .rst      (rst),
    .push     (op_push),
    .push_op  (push_op),
    .full     (op_full),
    .pop      (op_pop),
    .nonempty (op_nonempty),
    .head_op  (head_op)
  );

  // The back end performs all slot RAM accesses in command order, which
  // keeps a later enqueue from overwriting a slot before an earlier dequeue
  // or display has read it. Its output register decouples it from the
  // consumer; read data is taken straight from the RAM's read register,
  // which holds while the result beat is stalled.
  cqe_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_nonempty),
    .op           (head_op),
    .op_pop       (op_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .data         (data),
    .status       (status),
    .last         (last),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule
